FILE: design/fdpa_pkg.sv
// Shared types, constants and single-precision arithmetic helpers for the dot-product unit.
package fdpa_pkg;

  localparam int FieldLanes = 4;
  localparam int QueueDepth = 2;
  localparam logic [31:0] CanonNan = 32'h7FC0_0000;

  // One queued word: converted operands plus control.
  typedef struct packed {
    logic [FieldLanes-1:0][31:0] act;
    logic [FieldLanes-1:0][31:0] wt;
    logic [2:0]                  lanes;
    logic [31:0]                 bias;
    logic                        first;
    logic                        last;
  } item_t;

  // Unrounded value m * 2^(e-150), or a ready special result.
  typedef struct packed {
    logic               sign;
    logic signed [11:0] e;
    logic [47:0]        m;
    logic               spec;
    logic [31:0]        spec_val;
  } nrm_in_t;

  // Normalize plan: target exponent and signed shift (positive = right).
  typedef struct packed {
    logic               sign;
    logic signed [11:0] et;
    logic signed [11:0] s;
    logic [47:0]        m;
    logic               spec;
    logic [31:0]        spec_val;
  } nrm_mid_t;

  // Exact half to single conversion.
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  k;
    logic [9:0]  nm;
    logic [7:0]  ef;
    logic [31:0] o;
    ex  = h[14:10];
    man = h[9:0];
    k   = '0;
    nm  = '0;
    ef  = '0;
    o   = '0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) k = 4'(i);
    end
    if (ex == 5'd0) begin
      if (man != 10'd0) begin
        // subnormal half: leading one becomes the hidden bit
        nm = man << (4'd10 - k);
        ef = 8'd103 + {4'b0, k};
        o  = {1'b0, ef, nm, 13'b0};
      end
    end else if (ex == 5'h1F) begin
      o = {1'b0, 8'hFF, man, 13'b0};
      if (man != 10'd0) o = o | 32'h0040_0000;
    end else begin
      ef = {3'b0, ex} + 8'd112;
      o  = {1'b0, ef, man, 13'b0};
    end
    return {h[15], o[30:0]};
  endfunction

  // Product setup: exact 48-bit mantissa product and specials.
  function automatic nrm_in_t fp_mul_unpack(input logic [31:0] a, input logic [31:0] b);
    nrm_in_t r;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic nan_a, nan_b, inf_a, inf_b, zer_a, zer_b;
    ea    = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma    = {|a[30:23], a[22:0]};
    mb    = {|b[30:23], b[22:0]};
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    zer_a = (a[30:0] == 31'd0);
    zer_b = (b[30:0] == 31'd0);
    r.sign     = a[31] ^ b[31];
    r.e        = $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd150;
    r.m        = {24'b0, ma} * {24'b0, mb};
    r.spec     = 1'b0;
    r.spec_val = '0;
    if (nan_a || nan_b || (inf_a && zer_b) || (zer_a && inf_b)) begin
      r.spec     = 1'b1;
      r.spec_val = CanonNan;
    end else if (inf_a || inf_b) begin
      r.spec     = 1'b1;
      r.spec_val = {r.sign, 8'hFF, 23'd0};
    end
    return r;
  endfunction

  // Add setup: order by magnitude, align with guard/round/sticky, add or subtract.
  function automatic nrm_in_t fp_add_unpack(input logic [31:0] a, input logic [31:0] b);
    nrm_in_t r;
    logic [31:0] x, y;
    logic [7:0]  ex, ey, d;
    logic [4:0]  dc;
    logic [26:0] mx3, my3, sh, yal;
    logic [27:0] sum;
    logic nan_a, nan_b, inf_a, inf_b;
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    if (a[30:0] < b[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    ex  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey  = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    d   = ex - ey;
    dc  = (d > 8'd27) ? 5'd27 : d[4:0];
    mx3 = {|x[30:23], x[22:0], 3'b0};
    my3 = {|y[30:23], y[22:0], 3'b0};
    sh  = my3 >> dc;
    yal = sh | {26'b0, ((sh << dc) != my3)};
    if (x[31] == y[31]) sum = {1'b0, mx3} + {1'b0, yal};
    else                sum = {1'b0, mx3} - {1'b0, yal};
    r.sign     = (sum == 28'd0) ? (x[31] & y[31]) : x[31];
    r.e        = $signed({4'b0, ex}) - 12'sd3;
    r.m        = {20'b0, sum};
    r.spec     = 1'b0;
    r.spec_val = '0;
    if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) begin
      r.spec     = 1'b1;
      r.spec_val = CanonNan;
    end else if (inf_a) begin
      r.spec     = 1'b1;
      r.spec_val = a;
    end else if (inf_b) begin
      r.spec     = 1'b1;
      r.spec_val = b;
    end
    return r;
  endfunction

  // Leading-one search and shift plan, clamped at the subnormal exponent.
  function automatic nrm_mid_t nrm_plan(input nrm_in_t n);
    nrm_mid_t r;
    logic [5:0] p;
    logic signed [11:0] et;
    p = '0;
    for (int i = 0; i < 48; i++) begin
      if (n.m[i]) p = 6'(i);
    end
    et = n.e + $signed({6'b0, p}) - 12'sd23;
    if (et < 12'sd1) et = 12'sd1;
    r.sign     = n.sign;
    r.et       = et;
    r.s        = et - n.e;
    r.m        = n.m;
    r.spec     = n.spec;
    r.spec_val = n.spec_val;
    return r;
  endfunction

  // Shift, round to nearest even, pack.
  function automatic logic [31:0] nrm_round(input nrm_mid_t n);
    logic [72:0] w, sh;
    logic [6:0]  sc;
    logic [4:0]  ls;
    logic [11:0] neg_s;
    logic [23:0] mant;
    logic [24:0] mr;
    logic        g, st;
    logic signed [11:0] et2;
    logic [31:0] r;
    w     = {n.m, 25'b0};
    sh    = '0;
    g     = 1'b0;
    st    = 1'b0;
    neg_s = 12'd0 - n.s;
    ls    = neg_s[4:0];
    sc    = (n.s > 12'sd73) ? 7'd73 : n.s[6:0];
    if (n.s < 12'sd0) begin
      mant = 24'(n.m << ls);
    end else begin
      sh   = w >> sc;
      st   = ((sh << sc) != w) || (sh[23:0] != 24'd0);
      g    = sh[24];
      mant = sh[48:25];
    end
    mr  = {1'b0, mant} + {24'b0, (g & (st | mant[0]))};
    et2 = n.et;
    if (mr[24]) begin
      mant = mr[24:1];
      et2  = n.et + 12'sd1;
    end else begin
      mant = mr[23:0];
    end
    if (et2 >= 12'sd255) r = {n.sign, 8'hFF, 23'd0};
    else if ((et2 == 12'sd1) && !mant[23]) r = {n.sign, 8'h00, mant[22:0]};
    else r = {n.sign, et2[7:0], mant[22:0]};
    if (n.m == 48'd0) r = {n.sign, 31'd0};
    if (n.spec) r = n.spec_val;
    return r;
  endfunction

  function automatic logic [31:0] canon_nan(input logic [31:0] v);
    return ((v[30:23] == 8'hFF) && (v[22:0] != 23'd0)) ? CanonNan : v;
  endfunction

endpackage

FILE: design/float_dot_product_accumulator.sv
// The back end takes one queued word at a time; the shared multiply/add/normalize/round
//   sequence runs each lane as multiply, normalize, round, add, normalize, round on the sum.
// Input words are queued back to back in a two-word queue until it is full (in_stall_o).
// Reset (async, active low) clears the sum to +0.0, the weight format to single,
//   the queue and the output valid flag.
module float_dot_product_accumulator import fdpa_pkg::*; #(
  parameter int LANES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] act_lane0_i,
  input  logic [31:0] act_lane1_i,
  input  logic [31:0] act_lane2_i,
  input  logic [31:0] act_lane3_i,
  input  logic [31:0] wt_lane0_i,
  input  logic [31:0] wt_lane1_i,
  input  logic [31:0] wt_lane2_i,
  input  logic [31:0] wt_lane3_i,
  input  logic [2:0]  lanes_used_i,
  input  logic [31:0] bias_value_i,
  input  logic        first_item_i,
  input  logic        last_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] dot_sum_o
);

  logic  q_full, q_push, q_pop, q_valid;
  item_t q_in, q_out;

  fdpa_front #(.LANES(LANES)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .act_lane0_i, .act_lane1_i, .act_lane2_i, .act_lane3_i,
    .wt_lane0_i, .wt_lane1_i, .wt_lane2_i, .wt_lane3_i,
    .lanes_used_i, .bias_value_i, .first_item_i, .last_item_i,
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_item_o (q_in)
  );

  fdpa_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  fdpa_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid),
    .q_item_i  (q_out),
    .q_pop_o   (q_pop),
    .out_valid_o, .out_stall_i, .dot_sum_o
  );

endmodule

FILE: design/fdpa_front.sv
// Front end: weight format register, half-to-single conversion, lane clamp, queue push.
module fdpa_front import fdpa_pkg::*; #(
  parameter int LANES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] act_lane0_i,
  input  logic [31:0] act_lane1_i,
  input  logic [31:0] act_lane2_i,
  input  logic [31:0] act_lane3_i,
  input  logic [31:0] wt_lane0_i,
  input  logic [31:0] wt_lane1_i,
  input  logic [31:0] wt_lane2_i,
  input  logic [31:0] wt_lane3_i,
  input  logic [2:0]  lanes_used_i,
  input  logic [31:0] bias_value_i,
  input  logic        first_item_i,
  input  logic        last_item_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output item_t       q_item_o
);

  localparam logic [2:0] LaneCap = 3'((LANES < FieldLanes) ? LANES : FieldLanes);

  logic                        wfmt_q;
  logic [FieldLanes-1:0][31:0] wt_raw;

  // weight format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wfmt_q <= 1'b0;
    end else if (cfg_we_i) begin
      wfmt_q <= cfg_wdata_i;
    end
  end

  assign wt_raw = {wt_lane3_i, wt_lane2_i, wt_lane1_i, wt_lane0_i};

  // build the queued word
  always_comb begin
    q_item_o.act   = {act_lane3_i, act_lane2_i, act_lane1_i, act_lane0_i};
    for (int i = 0; i < FieldLanes; i++) begin
      q_item_o.wt[i] = wfmt_q ? half_to_single(wt_raw[i][15:0]) : wt_raw[i];
    end
    q_item_o.lanes = (lanes_used_i > LaneCap) ? LaneCap : lanes_used_i;
    q_item_o.bias  = bias_value_i;
    q_item_o.first = first_item_i;
    q_item_o.last  = last_item_i;
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

FILE: design/fdpa_queue.sv
// Two-word queue between front end and arithmetic back end.
module fdpa_queue import fdpa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  item_t             mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= item_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

FILE: design/fdpa_back.sv
// Back end: lane sequencer with shared multiply, add, normalize and round steps.
module fdpa_back import fdpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] dot_sum_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StAdd  = 3'd2;
  localparam logic [2:0] StNlz  = 3'd3;
  localparam logic [2:0] StNrnd = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0]  state_q, state_d;
  item_t       item_q;
  logic [1:0]  idx_q;
  logic        op_add_q;
  nrm_in_t     nin_q;
  nrm_mid_t    nmid_q;
  logic [31:0] prod_q, sum_q, dot_sum_q;
  logic        out_valid_q;
  logic [31:0] rnd;
  logic        out_free;
  logic        out_load;
  logic        lane_end;

  assign rnd      = nrm_round(nmid_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == StDone) && item_q.last && out_free;
  assign lane_end = ({1'b0, idx_q} + 3'd1) == item_q.lanes;
  assign q_pop_o  = (state_q == StIdle) && q_valid_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (q_valid_i) state_d = (q_item_i.lanes == 3'd0) ? StDone : StMul;
      StMul:  state_d = StNlz;
      StAdd:  state_d = StNlz;
      StNlz:  state_d = StNrnd;
      StNrnd: state_d = !op_add_q ? StAdd : (lane_end ? StDone : StMul);
      StDone: if (!item_q.last || out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          idx_q <= '0;
          if (q_valid_i && q_item_i.first) sum_q <= q_item_i.bias;
        end
        StNrnd: begin
          if (op_add_q) begin
            sum_q <= rnd;
            idx_q <= idx_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: if (q_valid_i) item_q <= q_item_i;
      StMul: begin
        nin_q    <= fp_mul_unpack(item_q.act[idx_q], item_q.wt[idx_q]);
        op_add_q <= 1'b0;
      end
      StAdd: begin
        nin_q    <= fp_add_unpack(sum_q, prod_q);
        op_add_q <= 1'b1;
      end
      StNlz:  nmid_q <= nrm_plan(nin_q);
      StNrnd: if (!op_add_q) prod_q <= rnd;
      StDone: if (out_load) dot_sum_q <= canon_nan(sum_q);
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign dot_sum_o   = dot_sum_q;

endmodule

FILE: design/fdpa_checker.sv
// Port-level checks for the dot-product unit, bound to the top level.
module fdpa_checker import fdpa_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] dot_sum_o
);

  // output word held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(dot_sum_o))
    else $error("result word changed under stall");

  // any NaN leaves in canonical form
  a_nan_canon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (dot_sum_o[30:23] == 8'hFF) && (dot_sum_o[22:0] != 23'd0)
    |-> dot_sum_o == CanonNan)
    else $error("non-canonical NaN on result");

  // no result right out of reset
  a_rst_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind float_dot_product_accumulator fdpa_checker u_fdpa_checker (.*);

FILE: dv/tb.sv
// Testbench for float_dot_product_accumulator: directed table plus random dot products.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HoldCycles   = 400;
  localparam int SettleCycles = 120;

  typedef struct packed {
    logic [3:0][31:0] act;
    logic [3:0][31:0] wt;
    logic [2:0]       lanes;
    logic [31:0]      bias;
    logic             first;
    logic             last;
  } word_t;

  typedef struct packed {
    word_t       w;
    logic        fmt;
    logic        typed;
    logic [31:0] sum;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [31:0] act_lane0_i = '0, act_lane1_i = '0, act_lane2_i = '0, act_lane3_i = '0;
  logic [31:0] wt_lane0_i = '0, wt_lane1_i = '0, wt_lane2_i = '0, wt_lane3_i = '0;
  logic [2:0]  lanes_used_i = '0;
  logic [31:0] bias_value_i = '0;
  logic first_item_i = 1'b0;
  logic last_item_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [31:0] dot_sum_o;

  float_dot_product_accumulator dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .act_lane0_i, .act_lane1_i, .act_lane2_i, .act_lane3_i,
    .wt_lane0_i, .wt_lane1_i, .wt_lane2_i, .wt_lane3_i,
    .lanes_used_i, .bias_value_i, .first_item_i, .last_item_i,
    .out_valid_o, .out_stall_i, .dot_sum_o
  );

  always #10 clk_i = ~clk_i;

  // predictor state and bookkeeping
  logic [31:0] model_sum = '0;
  logic        model_fmt = 1'b0;
  logic [31:0] sums_due[$];
  int          fail_count = 0;
  bit          hold_req = 1'b0;
  bit          quiet = 1'b0;
  int          hold_left = 0;
  int          stall_left = 0;
  row_t        dir_rows[$];

  // round m * 2^e_lsb to single, nearest even, with subnormals and overflow
  function automatic logic [31:0] round_pack(logic sgn, int e_lsb, logic [63:0] m);
    int p, e, s;
    logic [63:0] mant, low;
    logic g, st;
    if (m == 64'd0) return {sgn, 31'd0};
    p = 0;
    for (int i = 0; i < 64; i++) if (m[i]) p = i;
    e = p + e_lsb + 127;
    if (e < 1) e = 1;
    s = (e - 150) - e_lsb;
    g = 1'b0;
    st = 1'b0;
    if (s <= 0) begin
      mant = m << (-s);
    end else if (s > 64) begin
      mant = '0;
      st = 1'b1;
    end else begin
      mant = m >> s;
      g = m[s-1];
      low = m << (65 - s);
      st = (s > 1) && (low != 64'd0);
    end
    if (g && (st || mant[0])) mant = mant + 64'd1;
    if (mant[24]) begin
      mant = mant >> 1;
      e++;
    end
    if (e >= 255) return {sgn, 8'hFF, 23'd0};
    return {sgn, mant[23] ? 8'(e) : 8'd0, mant[22:0]};
  endfunction

  function automatic bit is_nan(logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  function automatic bit is_inf(logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
  endfunction

  function automatic logic [31:0] half_widen(logic [15:0] h);
    logic [9:0] man;
    int e;
    man = h[9:0];
    if (h[14:10] == 5'd0) begin
      if (man == 10'd0) return {h[15], 31'd0};
      e = -14;
      while (!man[9]) begin
        man = man << 1;
        e--;
      end
      // the leading one moves into the hidden bit
      man = man << 1;
      e--;
      return {h[15], 8'(e + 127), man, 13'd0};
    end
    if (h[14:10] == 5'h1F)
      return {h[15], 8'hFF, man | (man != 10'd0 ? 10'h200 : 10'h0), 13'd0};
    return {h[15], 8'(h[14:10] + 112), man, 13'd0};
  endfunction

  function automatic logic [31:0] fp_mult(logic [31:0] a, logic [31:0] b);
    logic sgn;
    logic [63:0] ma, mb;
    int ea, eb;
    sgn = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return fdpa_pkg::CanonNan;
    if ((is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0))
      return fdpa_pkg::CanonNan;
    if (is_inf(a) || is_inf(b)) return {sgn, 8'hFF, 23'd0};
    ea = (a[30:23] == 0) ? 1 : a[30:23];
    eb = (b[30:23] == 0) ? 1 : b[30:23];
    ma = {40'd0, |a[30:23], a[22:0]};
    mb = {40'd0, |b[30:23], b[22:0]};
    return round_pack(sgn, ea + eb - 300, ma * mb);
  endfunction

  function automatic logic [31:0] fp_sum(logic [31:0] a, logic [31:0] b);
    logic [31:0] x, y;
    logic [63:0] mx, my, yal, tot;
    int ex, ey, d;
    if (is_nan(a) || is_nan(b)) return fdpa_pkg::CanonNan;
    if (is_inf(a) && is_inf(b) && a[31] != b[31]) return fdpa_pkg::CanonNan;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] < b[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    ex = (x[30:23] == 0) ? 1 : x[30:23];
    ey = (y[30:23] == 0) ? 1 : y[30:23];
    d = ex - ey;
    mx = {40'd0, |x[30:23], x[22:0]} << 26;
    my = {40'd0, |y[30:23], y[22:0]} << 26;
    // 26 extra bits keep the align exact until the shift is wide enough for sticky
    if (d >= 64) yal = {63'd0, my != 0};
    else yal = (my >> d) | {63'd0, ((my >> d) << d) != my};
    tot = (x[31] == y[31]) ? mx + yal : mx - yal;
    if (tot == 64'd0) return {x[31] & y[31], 31'd0};
    return round_pack(x[31], ex - 176, tot);
  endfunction

  // one accepted word: update the running sum, report whether a result is due
  task automatic accumulate(input word_t w, output bit emit, output logic [31:0] res);
    int n;
    logic [31:0] wb;
    n = (w.lanes > 4) ? 4 : w.lanes;
    if (w.first) model_sum = w.bias;
    for (int i = 0; i < n; i++) begin
      wb = model_fmt ? half_widen(w.wt[i][15:0]) : w.wt[i];
      model_sum = fp_sum(model_sum, fp_mult(w.act[i], wb));
    end
    emit = w.last;
    res = is_nan(model_sum) ? fdpa_pkg::CanonNan : model_sum;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one word, wait for acceptance, then drop valid for the requested gap, if any
  task automatic send_word(input word_t w, input bit typed, input logic [31:0] typed_sum,
                           input int gap);
    bit emit;
    logic [31:0] res;
    in_valid_i   <= 1'b1;
    act_lane0_i  <= w.act[0];
    act_lane1_i  <= w.act[1];
    act_lane2_i  <= w.act[2];
    act_lane3_i  <= w.act[3];
    wt_lane0_i   <= w.wt[0];
    wt_lane1_i   <= w.wt[1];
    wt_lane2_i   <= w.wt[2];
    wt_lane3_i   <= w.wt[3];
    lanes_used_i <= w.lanes;
    bias_value_i <= w.bias;
    first_item_i <= w.first;
    last_item_i  <= w.last;
    do @(posedge clk_i); while (in_stall_o);
    accumulate(w, emit, res);
    if (emit) sums_due = {sums_due, (typed ? typed_sum : res)};
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drain: every result back, then the block's own latency for silent words
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_format(input logic fmt);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= fmt;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    model_fmt = fmt;
  endtask

  function automatic logic [31:0] rand_single();
    logic [31:0] picks[8] = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                              32'h7FC0_0000, 32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF};
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return picks[$urandom_range(0, 7)];
      2: return {1'($urandom), 8'd0, 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] rand_weight(logic fmt);
    logic [15:0] hpicks[6] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E01, 16'h0001};
    logic [15:0] h;
    if (!fmt) return rand_single();
    case ($urandom_range(0, 9))
      0: h = 16'($urandom);
      1: h = hpicks[$urandom_range(0, 5)];
      default: h = {1'($urandom), 5'($urandom_range(9, 20)), 10'($urandom)};
    endcase
    return {16'($urandom), h};
  endfunction

  function automatic word_t rand_word(logic fmt, bit fst, bit lst);
    word_t w;
    for (int i = 0; i < 4; i++) begin
      w.act[i] = rand_single();
      w.wt[i]  = rand_weight(fmt);
    end
    w.lanes = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
    w.bias  = rand_single();
    w.first = fst;
    w.last  = lst;
    return w;
  endfunction

  task automatic add_row(input logic [31:0] a0, input logic [31:0] w0, input logic [2:0] n,
                         input logic [31:0] bias, input bit fst, input bit lst,
                         input logic fmt, input bit typed, input logic [31:0] sum);
    row_t r;
    r.w.act   = {4{a0}};
    r.w.wt    = {4{w0}};
    r.w.lanes = n;
    r.w.bias  = bias;
    r.w.first = fst;
    r.w.last  = lst;
    r.fmt     = fmt;
    r.typed   = typed;
    r.sum     = sum;
    dir_rows = {dir_rows, r};
  endtask

  // receiver: random stalls, one long hold-off on request, result check
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (sums_due.size() == 0) begin
        $error("dot_sum: unexpected word, actual %h", dot_sum_o);
        fail_count++;
      end else begin
        if (dot_sum_o !== sums_due[0]) begin
          $error("dot_sum: expected %h actual %h", sums_due[0], dot_sum_o);
          fail_count++;
        end
        void'(sums_due.pop_front());
      end
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (quiet || $urandom_range(0, 9) < 7) begin
      out_stall_i <= 1'b0;
    end else begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end
  end

  // run limit
  initial begin
    #30ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int sent;
    int len;
    logic fmt;
    word_t w;
    // activations sweep the extremes; one row per special case
    add_row(32'h0, 32'h0, 3'd0, 32'h3F80_0000, 1, 1, 0, 1, 32'h3F80_0000);
    add_row(32'h7F80_0001, 32'h3F80_0000, 3'd1, 32'h0, 1, 1, 0, 1, 32'h7FC0_0000);
    add_row(32'h7F80_0000, 32'h0, 3'd1, 32'h0, 1, 1, 0, 1, 32'h7FC0_0000);
    add_row(32'h4000_0000, 32'h4040_0000, 3'd1, 32'h3F80_0000, 1, 1, 0, 1, 32'h40E0_0000);
    add_row(32'h7F7F_FFFF, 32'h4000_0000, 3'd1, 32'h0, 1, 1, 0, 1, 32'h7F80_0000);
    add_row(32'h3F80_0000, 32'h3F80_0000, 3'd7, 32'h0, 1, 1, 0, 1, 32'h4080_0000);
    add_row(32'h0, 32'h0, 3'd4, 32'h8000_0000, 1, 1, 0, 1, 32'h0);
    add_row(32'h0000_0001, 32'h3F80_0000, 3'd1, 32'h0, 1, 1, 0, 1, 32'h0000_0001);
    add_row(32'h0000_0001, 32'h3F00_0000, 3'd1, 32'h8000_0000, 1, 1, 0, 0, 32'h0);
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4, 32'hFFFF_FFFF, 1, 1, 0, 1, 32'h7FC0_0000);
    add_row(32'hBF80_0000, 32'h3F80_0000, 3'd1, 32'h3F80_0000, 1, 1, 0, 1, 32'h0);
    // continuation without a first word, then a split dot product
    add_row(32'h3FC0_0000, 32'h4020_0000, 3'd3, 32'h4100_0000, 0, 1, 0, 0, 32'h0);
    add_row(32'h3DCC_CCCD, 32'h3E4C_CCCD, 3'd4, 32'h3F80_0000, 1, 0, 0, 0, 32'h0);
    add_row(32'hC2C8_0000, 32'h3A83_126F, 3'd2, 32'h0, 0, 0, 0, 0, 32'h0);
    add_row(32'h0, 32'h0, 3'd0, 32'h4000_0000, 0, 1, 0, 0, 32'h0);
    // half weights, upper bits ignored
    add_row(32'h4000_0000, 32'hFFFF_3C00, 3'd1, 32'h0, 1, 1, 1, 1, 32'h4000_0000);
    add_row(32'h3F80_0000, 32'h0000_7C00, 3'd1, 32'h0, 1, 1, 1, 1, 32'h7F80_0000);
    add_row(32'h3F80_0000, 32'h0000_7E00, 3'd1, 32'h0, 1, 1, 1, 1, 32'h7FC0_0000);
    add_row(32'h3F80_0000, 32'h0000_0001, 3'd1, 32'h0, 1, 1, 1, 1, 32'h3380_0000);
    add_row(32'h3F80_0000, 32'h0000_FC00, 3'd1, 32'h0, 1, 1, 1, 1, 32'hFF80_0000);
    add_row(32'h3F80_0000, 32'h0000_7BFF, 3'd1, 32'h0, 1, 1, 1, 1, 32'h477F_E000);
    add_row(32'h3F80_0000, 32'hA5A5_03FF, 3'd4, 32'h0, 1, 1, 1, 0, 32'h0);
    add_row(32'h0, 32'h0, 3'd0, 32'h0, 0, 1, 1, 0, 32'h0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_format(1'b0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].fmt != model_fmt) begin
        drain();
        write_format(dir_rows[i].fmt);
      end
      send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].sum, pick_gap());
    end

    // random phases: alternating formats, one without idling, one with a long hold-off
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      fmt = ph[0] ? 1'b0 : 1'b1;
      write_format(fmt);
      quiet = (ph == 1);
      if (ph == 2) hold_req = 1'b1;
      sent = 0;
      while (sent < 260) begin
        if ($urandom_range(0, 9) < 8) begin
          len = $urandom_range(1, 6);
          for (int k = 0; k < len; k++) begin
            w = rand_word(fmt, k == 0, k == len - 1);
            send_word(w, 1'b0, 32'h0, (quiet || ph == 2) ? 0 : pick_gap());
          end
          sent += len;
        end else begin
          w = rand_word(fmt, 1'($urandom), 1'($urandom));
          send_word(w, 1'b0, 32'h0, quiet ? 0 : pick_gap());
          sent++;
        end
      end
    end

    in_valid_i <= 1'b0;
    quiet = 1'b1;
    while (sums_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
